### rtl/sme_pkg.sv
// Shared types, codes and constants of the stack machine executor.
package sme_pkg;

  localparam int unsigned StackDepthDefault = 32;
  localparam int unsigned ActionW           = 4;
  localparam int unsigned WordW             = 64;
  localparam int unsigned PcW               = 32;
  localparam int unsigned ErrW              = 3;
  localparam int unsigned DepthW            = 6;
  localparam int unsigned DumpIdxW          = 5;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned QueuePtrW         = $clog2(QueueDepth);
  localparam int unsigned QueueCntW         = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] BuiltinDump = WordW'(1);

  typedef enum logic [ActionW-1:0] {
    OP_HALT       = 4'd0,
    OP_PUSH_INT   = 4'd1,
    OP_CALL       = 4'd2,
    OP_DUP        = 4'd3,
    OP_ROTATE     = 4'd4,
    OP_ADD        = 4'd5,
    OP_PUSH_LABEL = 4'd6,
    OP_JUMP       = 4'd7
  } opcode_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK        = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_BUILTIN   = 3'd3,
    ERR_OPCODE    = 3'd4,
    ERR_HALTED    = 3'd5
  } err_e;

  // Instruction class as seen by the execution side.
  typedef enum logic [3:0] {
    K_HALT,
    K_PUSH,
    K_DUP,
    K_ROTATE,
    K_ADD,
    K_JUMP,
    K_DUMP,
    K_BAD_BUILTIN,
    K_BAD_OPCODE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [WordW-1:0]  operand;
  } cmd_t;

  // Queue handshake between the front and the back.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/sme_front.sv
// Front end: accepts instruction requests and classifies them into commands.
module sme_front import sme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [WordW-1:0]   operand_i,
  input  q_stat_t            q_stat_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic seen_q;
  logic seen_d;

  // Decode the opcode; the builtin number is checked here as well.
  always_comb begin
    cmd_o.operand = operand_i;
    unique case (action_i)
      OP_HALT:                  cmd_o.kind = K_HALT;
      OP_PUSH_INT, OP_PUSH_LABEL: cmd_o.kind = K_PUSH;
      OP_CALL:                  cmd_o.kind = (operand_i == BuiltinDump) ? K_DUMP : K_BAD_BUILTIN;
      OP_DUP:                   cmd_o.kind = K_DUP;
      OP_ROTATE:                cmd_o.kind = K_ROTATE;
      OP_ADD:                   cmd_o.kind = K_ADD;
      OP_JUMP:                  cmd_o.kind = K_JUMP;
      default:                  cmd_o.kind = K_BAD_OPCODE;
    endcase
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Marks that at least one request has entered since reset.
  assign seen_d = seen_q | push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_empty_before_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> q_stat_i.empty)
    else $error("queue holds a command before any request was accepted");
`endif

endmodule

### rtl/sme_queue.sv
// Short command queue between the front end and the execution back end.
module sme_queue import sme_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  input  cmd_t    cmd_i,
  output q_stat_t stat_o,
  output cmd_t    cmd_o
);

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign cmd_o        = slot_q[rd_ptr_q];

  assign wr_ptr_d = ctrl_i.push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
  assign rd_ptr_d = ctrl_i.pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
  assign count_d  = count_q + QueueCntW'(ctrl_i.push) - QueueCntW'(ctrl_i.pop);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !stat_o.empty)
    else $error("command popped from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count exceeds its depth");
`endif

endmodule

### rtl/sme_back.sv
// Execution back end: stack memory, top register, pointers and result register.
module sme_back import sme_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_stat_t             q_stat_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PcW-1:0]      next_pc_o,
  output logic                halted_o,
  output logic [ErrW-1:0]     error_code_o,
  output logic [DepthW-1:0]   depth_o,
  output logic [WordW-1:0]    top_value_o,
  output logic                dump_valid_o,
  output logic [DumpIdxW-1:0] dump_index_o,
  output logic [WordW-1:0]    dump_value_o,
  output logic                last_o
);

  localparam int unsigned PtrW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [PtrW-1:0]    sp_q, sp_d;
  logic [PcW-1:0]     pc_q, pc_d;
  logic               halt_q, halt_d;
  logic [WordW-1:0]   top_q, top_d;
  kind_e              kind_q, kind_d;
  logic [AddrW-1:0]   idx_q, idx_d;

  // Entries below the top; the top itself lives in top_q.
  logic [WordW-1:0]   mem [STACK_DEPTH];
  logic [WordW-1:0]   rd_q;
  logic               we, re;
  logic [AddrW-1:0]   wa, ra;
  logic [WordW-1:0]   wd;

  logic               out_valid_q;
  logic [PcW-1:0]     out_pc_q;
  logic               out_halted_q;
  err_e               out_err_q;
  logic [DepthW-1:0]  out_depth_q;
  logic [WordW-1:0]   out_top_q;
  logic               out_dv_q;
  logic [DumpIdxW-1:0] out_di_q;
  logic [WordW-1:0]   out_dval_q;
  logic               out_last_q;

  logic               out_free;
  logic               emit;
  err_e               emit_err;
  logic               emit_dv;
  logic [AddrW-1:0]   emit_di;
  logic [WordW-1:0]   emit_dval;
  logic               emit_last;
  logic [PtrW-1:0]    sp_m1, sp_m2, sp_m3;
  logic               stack_full;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop_o      = (state_q == S_IDLE) && !q_stat_i.empty && out_free;
  assign sp_m1      = sp_q - PtrW'(1);
  assign sp_m2      = sp_q - PtrW'(2);
  assign sp_m3      = sp_q - PtrW'(3);
  assign stack_full = (sp_q >= PtrW'(STACK_DEPTH));

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    pc_d      = pc_q;
    halt_d    = halt_q;
    top_d     = top_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    we        = 1'b0;
    wa        = sp_m1[AddrW-1:0];
    wd        = top_q;
    re        = 1'b0;
    ra        = sp_m2[AddrW-1:0];
    emit      = 1'b0;
    emit_err  = ERR_OK;
    emit_dv   = 1'b0;
    emit_di   = '0;
    emit_dval = '0;
    emit_last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          kind_d = cmd_i.kind;
          priority if (halt_q) begin
            emit     = 1'b1;
            emit_err = ERR_HALTED;
          end else begin
            pc_d = pc_q + PcW'(1);
            unique case (cmd_i.kind)
              K_HALT: begin
                halt_d = 1'b1;
                emit   = 1'b1;
              end
              K_PUSH: begin
                emit = 1'b1;
                if (stack_full) begin
                  emit_err = ERR_OVERFLOW;
                  halt_d   = 1'b1;
                end else begin
                  we    = (sp_q != '0);
                  top_d = cmd_i.operand;
                  sp_d  = sp_q + PtrW'(1);
                end
              end
              K_DUP: begin
                emit = 1'b1;
                if (sp_q == '0) begin
                  emit_err = ERR_UNDERFLOW;
                  halt_d   = 1'b1;
                end else if (stack_full) begin
                  emit_err = ERR_OVERFLOW;
                  halt_d   = 1'b1;
                end else begin
                  we   = 1'b1;
                  sp_d = sp_q + PtrW'(1);
                end
              end
              K_ROTATE: begin
                if (sp_q < PtrW'(3)) begin
                  emit     = 1'b1;
                  emit_err = ERR_UNDERFLOW;
                  halt_d   = 1'b1;
                end else begin
                  re      = 1'b1;
                  ra      = sp_m3[AddrW-1:0];
                  state_d = S_READ;
                end
              end
              K_ADD: begin
                if (sp_q < PtrW'(2)) begin
                  emit     = 1'b1;
                  emit_err = ERR_UNDERFLOW;
                  halt_d   = 1'b1;
                end else begin
                  re      = 1'b1;
                  state_d = S_READ;
                end
              end
              K_JUMP: begin
                pc_d = cmd_i.operand[PcW-1:0];
                emit = 1'b1;
              end
              K_DUMP: begin
                emit = 1'b1;
                if (sp_q != '0) begin
                  emit_dv   = 1'b1;
                  emit_di   = sp_m1[AddrW-1:0];
                  emit_dval = top_q;
                  emit_last = (sp_q == PtrW'(1));
                  if (sp_q != PtrW'(1)) begin
                    re      = 1'b1;
                    idx_d   = sp_m2[AddrW-1:0];
                    state_d = S_DUMP;
                  end
                end
              end
              K_BAD_BUILTIN: begin
                emit     = 1'b1;
                emit_err = ERR_BUILTIN;
                halt_d   = 1'b1;
              end
              default: begin
                emit     = 1'b1;
                emit_err = ERR_OPCODE;
                halt_d   = 1'b1;
              end
            endcase
          end
        end
      end
      S_READ: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (kind_q == K_ROTATE) begin
          we    = 1'b1;
          wa    = sp_m3[AddrW-1:0];
          top_d = rd_q;
        end else begin
          top_d = top_q + rd_q;
          sp_d  = sp_m1;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_dv   = 1'b1;
          emit_di   = idx_q;
          emit_dval = rd_q;
          emit_last = (idx_q == '0);
          if (idx_q != '0) begin
            re    = 1'b1;
            ra    = idx_q - AddrW'(1);
            idx_d = idx_q - AddrW'(1);
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    kind_q <= kind_d;
    idx_q <= idx_d;
    if (emit) begin
      out_pc_q     <= pc_d;
      out_halted_q <= halt_d;
      out_err_q    <= emit_err;
      out_depth_q  <= DepthW'(sp_d);
      out_top_q    <= (sp_d == '0) ? '0 : top_d;
      out_dv_q     <= emit_dv;
      out_di_q     <= DumpIdxW'(emit_di);
      out_dval_q   <= emit_dval;
      out_last_q   <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      out_valid_q <= emit | (out_valid_q & out_stall_i);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_pc_o    = out_pc_q;
  assign halted_o     = out_halted_q;
  assign error_code_o = out_err_q;
  assign depth_o      = out_depth_q;
  assign top_value_o  = out_top_q;
  assign dump_valid_o = out_dv_q;
  assign dump_index_o = out_di_q;
  assign dump_value_o = out_dval_q;
  assign last_o       = out_last_q;

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PtrW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("stack memory read and written in the same cycle");
  a_halted_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && halt_q) |=> ($stable(sp_q) && $stable(pc_q) && halt_q))
    else $error("state changed while halted");
  a_dump_shows_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && out_valid_q) |-> (out_dv_q && !out_last_q))
    else $error("dump run shows a non-entry result");
`endif

endmodule

### rtl/stack_machine_executor_top.sv
// Top level of the stack machine executor: front end, command queue, back end.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  in       | request   | in_valid_i/in_stall_o | action_i, operand_i
//  out      | result    | out_valid_o/out_stall_i | next_pc_o, halted_o, error_code_o,
//           |           |                       | depth_o, top_value_o, dump_valid_o,
//           |           |                       | dump_index_o, dump_value_o, last_o
//
// Halt, push, dup, jump, errors and requests after halt finish in the idle state, while
// add and rotate pass a read state, as the stack memory read port is registered. A dump
// of N>0 entries gives N results, one per cycle unless stalled, one read per lower entry.
// The front end takes a request whenever the two-entry command queue has room, so
// requests keep flowing while a result waits in the output register.
// Reset is asynchronous and active low; it clears the pointers, the program counter
// and the halt flag. The stack memory is not cleared; only written entries are read.
module stack_machine_executor_top import sme_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ActionW-1:0]  action_i,
  input  logic [WordW-1:0]    operand_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PcW-1:0]      next_pc_o,
  output logic                halted_o,
  output logic [ErrW-1:0]     error_code_o,
  output logic [DepthW-1:0]   depth_o,
  output logic [WordW-1:0]    top_value_o,
  output logic                dump_valid_o,
  output logic [DumpIdxW-1:0] dump_index_o,
  output logic [WordW-1:0]    dump_value_o,
  output logic                last_o
);

  // Commands flow front -> queue -> back; the queue decouples the two stall paths.
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  cmd_t    front_cmd;
  cmd_t    back_cmd;
  logic    q_push;
  logic    q_pop;

  // The front end pushes and the back end pops; both meet in one control word.
  assign q_ctrl = '{push: q_push, pop: q_pop};

  sme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .operand_i  (operand_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  sme_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .cmd_i  (front_cmd),
    .stat_o (q_stat),
    .cmd_o  (back_cmd)
  );

  // The back end pops a command only when its output register can take a result.
  sme_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .cmd_i        (back_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_pc_o    (next_pc_o),
    .halted_o     (halted_o),
    .error_code_o (error_code_o),
    .depth_o      (depth_o),
    .top_value_o  (top_value_o),
    .dump_valid_o (dump_valid_o),
    .dump_index_o (dump_index_o),
    .dump_value_o (dump_value_o),
    .last_o       (last_o)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the stack machine executor: random instruction streams and a predictor.
`timescale 1ns / 100ps

module tb_top;
  import sme_pkg::*;

  localparam int unsigned Depth       = StackDepthDefault;
  localparam int unsigned RandomInstr = 450;
  localparam int unsigned AfterHalt   = 20;
  // Longest legal quiet stretch is a long stall or a long send gap plus the time through
  // the pipeline; this limit leaves a wide margin on top of that.
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 50;
  localparam logic [ActionW-1:0] FirstBadOp = 4'd8;
  localparam logic [ActionW-1:0] LastBadOp  = 4'd15;

  typedef struct {
    logic [ActionW-1:0] action;
    logic [WordW-1:0]   operand;
  } instr_t;

  typedef struct {
    logic [PcW-1:0]      next_pc;
    logic                halted;
    logic [ErrW-1:0]     error_code;
    logic [DepthW-1:0]   depth;
    logic [WordW-1:0]    top_value;
    logic                dump_valid;
    logic [DumpIdxW-1:0] dump_index;
    logic [WordW-1:0]    dump_value;
    logic                last;
  } result_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [ActionW-1:0]  action_i    = '0;
  logic [WordW-1:0]    operand_i   = '0;
  logic                out_stall_i = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [PcW-1:0]      next_pc_o;
  logic                halted_o;
  logic [ErrW-1:0]     error_code_o;
  logic [DepthW-1:0]   depth_o;
  logic [WordW-1:0]    top_value_o;
  logic                dump_valid_o;
  logic [DumpIdxW-1:0] dump_index_o;
  logic [WordW-1:0]    dump_value_o;
  logic                last_o;

  // Instructions still to be sent, and results the predictor says must come back.
  instr_t  instr_queue[$];
  result_t due_results[$];

  // Shadow machine state kept by the predictor.
  logic [WordW-1:0]  mach_stack[Depth];
  logic [DepthW-1:0] mach_sp     = '0;
  logic [PcW-1:0]    mach_pc     = '0;
  logic              mach_halted = 1'b0;

  // Stack depth as seen by the generator, used to keep the stream free of errors.
  int unsigned gen_depth = 0;
  int unsigned gen_count = 0;

  int unsigned cyc          = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_wait    = 0;
  int unsigned stall_left   = 0;
  logic        in_fire      = 1'b0;

  stack_machine_executor_top #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .operand_i   (operand_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .next_pc_o   (next_pc_o),
    .halted_o    (halted_o),
    .error_code_o(error_code_o),
    .depth_o     (depth_o),
    .top_value_o (top_value_o),
    .dump_valid_o(dump_valid_o),
    .dump_index_o(dump_index_o),
    .dump_value_o(dump_value_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Pause length for either side. Most pauses are short and a few are long. Every
  // window of the cycle count cyc opens with a span in which neither side pauses.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((cyc % 3000) < 600) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Snapshot of the shadow machine as one result.
  function automatic result_t make_result(err_e err, logic dv, logic [DumpIdxW-1:0] didx,
                                          logic [WordW-1:0] dval, logic lastf);
    result_t r;
    r.next_pc    = mach_pc;
    r.halted     = mach_halted;
    r.error_code = err;
    r.depth      = mach_sp;
    r.top_value  = (mach_sp == 0) ? '0 : mach_stack[mach_sp - 1];
    r.dump_valid = dv;
    r.dump_index = didx;
    r.dump_value = dval;
    r.last       = lastf;
    return r;
  endfunction

  // Executes one instruction on the shadow machine and queues the results it causes.
  task automatic step_machine(input logic [ActionW-1:0] act, input logic [WordW-1:0] opnd);
    err_e             err;
    logic [WordW-1:0] tmp;
    err = ERR_OK;
    // Once stopped, the machine rejects everything and keeps its state.
    if (mach_halted) begin
      due_results.push_back(make_result(ERR_HALTED, 1'b0, '0, '0, 1'b1));
      return;
    end
    mach_pc = mach_pc + PcW'(1);
    case (act)
      OP_HALT: mach_halted = 1'b1;
      OP_PUSH_INT, OP_PUSH_LABEL: begin
        if (mach_sp >= Depth) begin
          err = ERR_OVERFLOW;
        end else begin
          mach_stack[mach_sp] = opnd;
          mach_sp = mach_sp + DepthW'(1);
        end
      end
      OP_CALL: begin
        if (opnd == BuiltinDump) begin
          // The dump walks the stack from the top down; an empty stack gives one
          // plain result.
          if (mach_sp == 0) begin
            due_results.push_back(make_result(ERR_OK, 1'b0, '0, '0, 1'b1));
          end else begin
            for (int i = mach_sp; i > 0; i--) begin
              due_results.push_back(make_result(ERR_OK, 1'b1, DumpIdxW'(i - 1),
                                                mach_stack[i - 1], i == 1));
            end
          end
          return;
        end
        err = ERR_BUILTIN;
      end
      OP_DUP: begin
        if (mach_sp < 1) begin
          err = ERR_UNDERFLOW;
        end else if (mach_sp >= Depth) begin
          err = ERR_OVERFLOW;
        end else begin
          mach_stack[mach_sp] = mach_stack[mach_sp - 1];
          mach_sp = mach_sp + DepthW'(1);
        end
      end
      OP_ROTATE: begin
        if (mach_sp < 3) begin
          err = ERR_UNDERFLOW;
        end else begin
          tmp = mach_stack[mach_sp - 1];
          mach_stack[mach_sp - 1] = mach_stack[mach_sp - 3];
          mach_stack[mach_sp - 3] = tmp;
        end
      end
      OP_ADD: begin
        if (mach_sp < 2) begin
          err = ERR_UNDERFLOW;
        end else begin
          mach_stack[mach_sp - 2] = mach_stack[mach_sp - 1] + mach_stack[mach_sp - 2];
          mach_sp = mach_sp - DepthW'(1);
        end
      end
      OP_JUMP: mach_pc = opnd[PcW-1:0];
      default: err = ERR_OPCODE;
    endcase
    if (err != ERR_OK) mach_halted = 1'b1;
    due_results.push_back(make_result(err, 1'b0, '0, '0, 1'b1));
  endtask

  // Operand values lean toward the extremes and single-bit patterns.
  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, WordW - 1);
      3:       return ~(64'd1 << $urandom_range(0, WordW - 1));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_instr(input logic [ActionW-1:0] act, input logic [WordW-1:0] opnd);
    instr_t it;
    it.action  = act;
    it.operand = opnd;
    instr_queue.push_back(it);
    gen_count++;
    case (act)
      OP_PUSH_INT, OP_PUSH_LABEL: if (gen_depth < Depth) gen_depth++;
      OP_DUP:                     if (gen_depth > 0 && gen_depth < Depth) gen_depth++;
      OP_ADD:                     if (gen_depth >= 2) gen_depth--;
      default: ;
    endcase
  endtask

  task automatic fill_stack();
    while (gen_depth < Depth)
      add_instr($urandom_range(0, 1) ? OP_PUSH_INT : OP_PUSH_LABEL, rand_word());
  endtask

  task automatic drain_to(input int unsigned level);
    while (gen_depth > level) add_instr(OP_ADD, rand_word());
  endtask

  // One instruction that cannot fail at the current generator depth.
  task automatic add_legal_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 28 && gen_depth < Depth)                     add_instr(OP_PUSH_INT, rand_word());
    else if (r < 38 && gen_depth < Depth)                add_instr(OP_PUSH_LABEL, rand_word());
    else if (r < 50 && gen_depth > 0 && gen_depth < Depth) add_instr(OP_DUP, rand_word());
    else if (r < 62 && gen_depth >= 3)                   add_instr(OP_ROTATE, rand_word());
    else if (r < 78 && gen_depth >= 2)                   add_instr(OP_ADD, rand_word());
    else if (r < 86)                                     add_instr(OP_JUMP, rand_word());
    else if (r < 96)                                     add_instr(OP_CALL, BuiltinDump);
    else if (gen_depth < 3)                              add_instr(OP_PUSH_INT, rand_word());
    else                                                 add_instr(OP_ADD, rand_word());
  endtask

  // Ends the run with one of the ways the machine stops, picked at random, then
  // sends more instructions that must all be rejected.
  task automatic add_stop_case();
    logic [WordW-1:0] w;
    case ($urandom_range(0, 7))
      0: add_instr(OP_HALT, rand_word());
      1: begin fill_stack(); add_instr(OP_PUSH_INT, rand_word());   end
      2: begin fill_stack(); add_instr(OP_PUSH_LABEL, rand_word()); end
      3: begin fill_stack(); add_instr(OP_DUP, rand_word());        end
      4: begin drain_to(1); add_instr(OP_ADD, rand_word());         end
      5: begin drain_to($urandom_range(1, 2)); add_instr(OP_ROTATE, rand_word()); end
      6: begin
        w = rand_word();
        if (w == BuiltinDump) w = '0;
        add_instr(OP_CALL, w);
      end
      default: add_instr(ActionW'($urandom_range(FirstBadOp, LastBadOp)), rand_word());
    endcase
    repeat (AfterHalt) begin
      // Half of the rejected requests carry invalid opcodes; in a quarter of the rest the operand is the dump number.
      if ($urandom_range(0, 1))
        add_instr(ActionW'($urandom_range(FirstBadOp, LastBadOp)), rand_word());
      else
        add_instr(ActionW'($urandom_range(0, FirstBadOp - 1)),
                  $urandom_range(0, 3) == 0 ? BuiltinDump : rand_word());
    end
  endtask

  // Stimulus: directed opening, error-free random stream, one stop case at the end.
  initial begin
    // A dump on the empty stack gives a single result with no entry.
    add_instr(OP_CALL, BuiltinDump);
    add_instr(OP_PUSH_INT, '0);
    add_instr(OP_PUSH_INT, '1);
    add_instr(OP_PUSH_LABEL, 64'h8000_0000_0000_0001);
    add_instr(OP_DUP, '1);
    add_instr(OP_ROTATE, '0);
    // The add wraps around 64 bits here.
    add_instr(OP_ADD, '0);
    add_instr(OP_PUSH_INT, 64'd1);
    add_instr(OP_ADD, '1);
    add_instr(OP_CALL, BuiltinDump);
    // Only the low 32 bits of a jump target count; the next step wraps the counter.
    add_instr(OP_JUMP, 64'hDEAD_BEEF_FFFF_FFFF);
    add_instr(OP_PUSH_LABEL, 64'h5555_5555_5555_5555);
    add_instr(OP_JUMP, '0);
    add_instr(OP_JUMP, rand_word());
    add_instr(OP_DUP, 64'hAAAA_AAAA_AAAA_AAAA);
    add_instr(OP_CALL, BuiltinDump);

    while (gen_count < RandomInstr) begin
      if ($urandom_range(0, 99) < 4) begin
        // Full stack, dumped whole, then worked back down through adds.
        fill_stack();
        add_instr(OP_CALL, BuiltinDump);
        drain_to($urandom_range(1, 8));
      end else begin
        add_legal_op();
      end
    end
    add_stop_case();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (instr_queue.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Request side: a new request goes out once the current one has been taken and the
  // chosen gap has passed. Valid stays high across back-to-back requests.
  always @(negedge clk_i) begin : request_drive
    instr_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_wait > 0) begin
        in_valid_i <= 1'b0;
        send_wait  <= send_wait - 1;
      end else if (instr_queue.size() != 0) begin
        nxt = instr_queue.pop_front();
        action_i   <= nxt.action;
        operand_i  <= nxt.operand;
        in_valid_i <= 1'b1;
        send_wait  <= pick_pause();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: stall in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_pause();
    end
  end

  // Every accepted request runs through the predictor right at the edge that takes it.
  always @(posedge clk_i) begin
    cyc     <= cyc + 1;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) step_machine(action_i, operand_i);
  end

  task automatic check_field(input string fname, input logic [WordW-1:0] exp_v,
                             input logic [WordW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Result checking against the oldest expectation, plus the stall watchdog.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual next_pc %0h error %0d",
                 $time, next_pc_o, error_code_o);
        mismatch_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("next_pc", want.next_pc, next_pc_o);
        check_field("halted", want.halted, halted_o);
        check_field("error_code", want.error_code, error_code_o);
        check_field("depth", want.depth, depth_o);
        check_field("top_value", want.top_value, top_value_o);
        check_field("dump_valid", want.dump_valid, dump_valid_o);
        check_field("dump_index", want.dump_index, dump_index_o);
        check_field("dump_value", want.dump_value, dump_value_o);
        check_field("last", want.last, last_o);
      end
    end
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
